### design/assert_macros.svh
// Assertion macros shared by the echo timer modules.
// Every check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge.
`define EPWD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the condition holds, the consequence holds at the next clock edge.
`define EPWD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### design/epwd_pkg.sv
// ----------------------------------------------------------------------------
// epwd_pkg: shared definitions for the echo pulse width timer
// Channel count, field widths, register codes and the structs that pass
// between the channel lanes, the result merge and the top level.
// ----------------------------------------------------------------------------
package epwd_pkg;

  localparam int CHANNELS      = 3;
  localparam int OVERFLOW_BITS = 6;

  localparam int CountW  = 16;
  localparam int TicksW  = 22;
  localparam int DistW   = 16;
  localparam int LevelsW = 3;
  localparam int ChanW   = 2;
  localparam int CfgW    = 16;
  localparam int MultW   = 11;
  localparam int ProdW   = TicksW + MultW;

  localparam logic [MultW-1:0]         DistMult     = MultW'(1114);
  localparam logic [CountW-1:0]        CountMax     = '1;
  localparam logic [DistW-1:0]         DistMax      = '1;
  localparam logic [CountW-1:0]        ReloadReset  = CountW'(65535);
  localparam logic [OVERFLOW_BITS-1:0] LimitReset   = OVERFLOW_BITS'(63);

  typedef enum logic {
    REG_RELOAD = 1'b0,
    REG_LIMIT  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CountW-1:0]        reload;
    logic [OVERFLOW_BITS-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic rd;
    logic level;
  } lane_ctl_t;

  typedef struct packed {
    logic              done;
    logic [TicksW-1:0] ticks;
    logic [DistW-1:0]  cm;
    logic [DistW-1:0]  last_dist;
  } lane_res_t;

  typedef struct packed {
    logic [ChanW-1:0]  channel;
    logic              done;
    logic [TicksW-1:0] ticks;
    logic [DistW-1:0]  cm;
  } result_t;

endpackage

### design/epwd_lane.sv
// ----------------------------------------------------------------------------
// epwd_lane: one echo channel
// Edge detection, pulse counter with overflow count and saturation, latched
// count, distance conversion and the last distance returned.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epwd_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  epwd_pkg::cfg_t      cfg,
  input  epwd_pkg::lane_ctl_t ctl,
  output epwd_pkg::lane_res_t res
);

  logic                                 prev_r, prev_nxt;
  logic                                 high_r, high_nxt;
  logic                                 done_r, done_nxt;
  logic [epwd_pkg::OVERFLOW_BITS-1:0]   ovf_r, ovf_nxt;
  logic [epwd_pkg::CountW-1:0]          cnt_r, cnt_nxt;
  logic [epwd_pkg::CountW-1:0]          latch_r, latch_nxt;
  logic [epwd_pkg::DistW-1:0]           last_r, last_nxt;
  logic [epwd_pkg::TicksW-1:0]          ticks;
  logic [epwd_pkg::ProdW-1:0]           prod;
  logic [epwd_pkg::DistW-1:0]           dist_cm;

  assign ticks   = epwd_pkg::TicksW'({ovf_r, latch_r});
  assign prod    = epwd_pkg::ProdW'(ticks) * epwd_pkg::ProdW'(epwd_pkg::DistMult);
  assign dist_cm = (|prod[epwd_pkg::ProdW-1:16 + epwd_pkg::DistW])
                   ? epwd_pkg::DistMax : prod[16 +: epwd_pkg::DistW];

  always_comb begin
    logic sat;
    sat       = 1'b0;
    prev_nxt  = prev_r;
    high_nxt  = high_r;
    done_nxt  = done_r;
    ovf_nxt   = ovf_r;
    cnt_nxt   = cnt_r;
    latch_nxt = latch_r;
    last_nxt  = last_r;
    if (ctl.tick) begin
      prev_nxt = ctl.level;
      if (!done_r) begin
        if (high_r) begin
          if (cnt_r >= cfg.reload) begin
            cnt_nxt = '0;
            if (ovf_r >= cfg.limit) begin
              done_nxt  = 1'b1;
              latch_nxt = epwd_pkg::CountMax;
              sat       = 1'b1;
            end else begin
              ovf_nxt = ovf_r + 1'b1;
            end
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (!sat && prev_r && !ctl.level) begin
            latch_nxt = cnt_nxt;
            done_nxt  = 1'b1;
          end
        end else if (ctl.level && !prev_r) begin
          cnt_nxt   = '0;
          ovf_nxt   = '0;
          latch_nxt = '0;
          high_nxt  = 1'b1;
        end
      end
    end else if (ctl.rd && done_r) begin
      last_nxt = dist_cm;
      done_nxt = 1'b0;
      high_nxt = 1'b0;
      ovf_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      high_r  <= 1'b0;
      done_r  <= 1'b0;
      ovf_r   <= '0;
      cnt_r   <= '0;
      latch_r <= '0;
      last_r  <= '0;
    end else begin
      prev_r  <= prev_nxt;
      high_r  <= high_nxt;
      done_r  <= done_nxt;
      ovf_r   <= ovf_nxt;
      cnt_r   <= cnt_nxt;
      latch_r <= latch_nxt;
      last_r  <= last_nxt;
    end
  end

  assign res.done      = done_r;
  assign res.ticks     = ticks;
  assign res.cm        = dist_cm;
  assign res.last_dist = last_r;

  `EPWD_ASSERT(a_done_needs_high, !done_r || high_r, "lane done without a measurement")
  `EPWD_ASSERT(a_idle_ovf_clear, high_r || (ovf_r == '0), "overflow count set while idle")
  `EPWD_ASSERT_NEXT(a_read_rearms, ctl.rd && !ctl.tick && done_r, !done_r && !high_r,
                    "read of a finished channel did not rearm it")

endmodule

### design/epwd_merge.sv
// ----------------------------------------------------------------------------
// epwd_merge: result selection and output buffer
// Picks the addressed lane's measurement for a read and holds results in a
// main register with one skid entry behind it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epwd_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  epwd_pkg::lane_res_t           lanes [epwd_pkg::CHANNELS],
  input  logic                          push,
  input  logic [epwd_pkg::ChanW-1:0]    sel,
  output logic                          full,
  output logic                          out_valid,
  input  logic                          out_stall,
  output epwd_pkg::result_t             out_res
);

  epwd_pkg::result_t new_res;
  epwd_pkg::result_t main_r, skid_r;
  logic              main_v_r, skid_v_r;
  logic              take;

  always_comb begin
    new_res         = '0;
    new_res.channel = sel;
    for (int c = 0; c < epwd_pkg::CHANNELS; c++) begin
      if (int'(sel) == c) begin
        new_res.done  = lanes[c].done;
        new_res.ticks = lanes[c].done ? lanes[c].ticks : '0;
        new_res.cm    = lanes[c].done ? lanes[c].cm : lanes[c].last_dist;
      end
    end
  end

  assign take = main_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        main_r   <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || take) begin
        main_r   <= new_res;
        main_v_r <= 1'b1;
      end else begin
        skid_r   <= new_res;
        skid_v_r <= 1'b1;
      end
    end else if (take) begin
      main_v_r <= 1'b0;
    end
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

  `EPWD_ASSERT(a_skid_behind_main, !skid_v_r || main_v_r, "skid entry without a main entry")
  `EPWD_ASSERT(a_no_push_when_full, !(push && skid_v_r), "result pushed into a full buffer")
  `EPWD_ASSERT(a_done_real_channel,
               !(main_v_r && main_r.done) || (int'(main_r.channel) < epwd_pkg::CHANNELS),
               "done result for a channel that does not exist")

endmodule

### design/echo_pulse_width_distance.sv
// ----------------------------------------------------------------------------
// echo_pulse_width_distance: three-channel ultrasonic echo timer
// Measures echo high time per channel in timer ticks and converts it to a
// distance in centimetres on a read request.
//
//   channel  direction  beat contents
//   in_      input      req_type, echo_levels, read_channel
//   out_     output     channel, done_res, pulse_ticks, distance_cm (reads only)
//   cfg_     input      reload_value (index 0), overflow_limit (index 1)
//
// One item is accepted per cycle unless stalled; read results are registered.
// Each channel lane updates its counter and edges on every accepted tick item.
// Results wait in a two-beat output buffer; in_stall rises only when it is full.
// Reset clears every channel; there is no clearing pass.
// ----------------------------------------------------------------------------
module echo_pulse_width_distance (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [epwd_pkg::LevelsW-1:0]    in_echo_levels,
  input  logic [epwd_pkg::ChanW-1:0]      in_read_channel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [epwd_pkg::ChanW-1:0]      out_channel,
  output logic                            out_done_res,
  output logic [epwd_pkg::TicksW-1:0]     out_pulse_ticks,
  output logic [epwd_pkg::DistW-1:0]      out_distance_cm,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [epwd_pkg::CfgW-1:0]       cfg_data
);

  epwd_pkg::cfg_t      cfg_r;
  epwd_pkg::lane_ctl_t ctl [epwd_pkg::CHANNELS];
  epwd_pkg::lane_res_t lanes [epwd_pkg::CHANNELS];
  epwd_pkg::result_t   res;
  logic                accept;
  logic                full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reload <= epwd_pkg::ReloadReset;
      cfg_r.limit  <= epwd_pkg::LimitReset;
    end else if (cfg_we) begin
      unique case (epwd_pkg::reg_idx_t'(cfg_index))
        epwd_pkg::REG_RELOAD: cfg_r.reload <= cfg_data;
        epwd_pkg::REG_LIMIT:  cfg_r.limit  <= cfg_data[epwd_pkg::OVERFLOW_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && !full;
  assign in_stall = full;

  for (genvar c = 0; c < epwd_pkg::CHANNELS; c++) begin : g_lane
    assign ctl[c].tick  = accept && !in_req_type;
    assign ctl[c].rd    = accept && in_req_type && (int'(in_read_channel) == c);
    assign ctl[c].level = in_echo_levels[c];

    epwd_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cfg   (cfg_r),
      .ctl   (ctl[c]),
      .res   (lanes[c])
    );
  end

  epwd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .lanes     (lanes),
    .push      (accept && in_req_type),
    .sel       (in_read_channel),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_channel     = res.channel;
  assign out_done_res    = res.done;
  assign out_pulse_ticks = res.ticks;
  assign out_distance_cm = res.cm;

endmodule
